[hdl/mbalp_pkg.sv]
// Shared constants and control types for the memory bank arbiter with loser priority.
`timescale 1ns / 1ps

package mbalp_pkg;

    localparam int DEF_MAX_REQUESTERS = 16;
    localparam int DEF_MAX_BANKS      = 64;

    localparam int REQ_W       = 4;
    localparam int MOD_W       = 6;
    localparam int CNT_W       = 16;
    localparam int AP_W        = 5;
    localparam int AM_W        = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;
    localparam int MOD_CODES   = 1 << MOD_W;

    localparam int RESULT_LIMIT = 16;
    localparam int RCNT_W       = $clog2(RESULT_LIMIT + 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CYCLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PROC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MOD  = 1'd1;

    localparam logic [AP_W-1:0] AP_RESET = 5'd16;
    localparam logic [AM_W-1:0] AM_RESET = 7'd64;

    // Controls for the priority order memory.
    typedef struct packed {
        logic clr;
        logic start;
        logic rd;
        logic put_denied;
        logic put_granted;
        logic put_np;
        logic copy;
        logic flip;
    } t_ord_ctl;

    // Controls for the requester state memory.
    typedef struct packed {
        logic clr;
        logic rd;
        logic upd;
        logic ld_wr;
        logic busy_clr;
    } t_req_ctl;

    // Arbitration outcome for the requester currently read.
    typedef struct packed {
        logic             grant;
        logic [MOD_W-1:0] module_idx;
        logic [CNT_W-1:0] wait_total;
        logic [CNT_W-1:0] grant_total;
    } t_req_info;

endpackage

[hdl/mbalp_req_unit.sv]
// Requester state memory with bank busy flags and saturating counter update.
`timescale 1ns / 1ps

module mbalp_req_unit #(
    parameter int MAX_REQUESTERS = mbalp_pkg::DEF_MAX_REQUESTERS,
    localparam int IW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mbalp_pkg::t_req_ctl            i_ctl,
    input  logic [IW-1:0]                  i_rd_addr,
    input  logic [IW-1:0]                  i_wr_addr,
    input  logic [mbalp_pkg::MOD_W-1:0]    i_ld_mod,
    input  logic [mbalp_pkg::AM_W-1:0]     i_nmod,
    output mbalp_pkg::t_req_info           o_info
);

    typedef struct packed {
        logic [mbalp_pkg::MOD_W-1:0] pend;
        logic [mbalp_pkg::CNT_W-1:0] waits;
        logic [mbalp_pkg::CNT_W-1:0] grants;
    } t_entry;

    t_entry                            r_mem [MAX_REQUESTERS];
    t_entry                            r_rdata;
    t_entry                            n_wdata;
    logic                              wr_en;
    logic                              grant;
    logic [mbalp_pkg::MOD_CODES-1:0]   r_busy;

    function automatic logic [mbalp_pkg::CNT_W-1:0] sat_inc(
        input logic [mbalp_pkg::CNT_W-1:0] v
    );
        return (v == '1) ? v : mbalp_pkg::CNT_W'(v + 1'b1);
    endfunction

    // A request is granted when its bank is active and nobody ahead took it.
    always_comb begin
        grant = (mbalp_pkg::AM_W'(r_rdata.pend) < i_nmod) && !r_busy[r_rdata.pend];
    end

    always_comb begin
        n_wdata = r_rdata;
        wr_en   = 1'b0;
        if (i_ctl.clr) begin
            n_wdata = '0;
            wr_en   = 1'b1;
        end else if (i_ctl.ld_wr) begin
            n_wdata.pend = i_ld_mod;
            wr_en        = 1'b1;
        end else if (i_ctl.upd) begin
            wr_en = 1'b1;
            if (grant) begin
                n_wdata.grants = sat_inc(r_rdata.grants);
            end else begin
                n_wdata.waits = sat_inc(r_rdata.waits);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_wr_addr] <= n_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (i_ctl.busy_clr) begin
            r_busy <= '0;
        end else if (i_ctl.upd && grant) begin
            r_busy[r_rdata.pend] <= 1'b1;
        end
    end

    assign o_info = '{
        grant:       grant,
        module_idx:  r_rdata.pend,
        wait_total:  r_rdata.waits,
        grant_total: sat_inc(r_rdata.grants)
    };

endmodule

[hdl/mbalp_order_unit.sv]
// Double-buffered priority order memory with partition write pointers.
`timescale 1ns / 1ps

module mbalp_order_unit #(
    parameter int MAX_REQUESTERS = mbalp_pkg::DEF_MAX_REQUESTERS,
    localparam int IW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1,
    localparam int CW = $clog2(MAX_REQUESTERS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mbalp_pkg::t_ord_ctl  i_ctl,
    input  logic [IW-1:0]        i_clr_addr,
    input  logic [IW-1:0]        i_rd_pos,
    input  logic [IW-1:0]        i_put_id,
    input  logic [CW-1:0]        i_nproc,
    output logic [IW-1:0]        o_id,
    output logic                 o_copy_done
);

    localparam int DEPTH = 2 * MAX_REQUESTERS;
    localparam int AW    = $clog2(DEPTH);

    logic [IW-1:0] r_mem [DEPTH];
    logic [IW-1:0] r_rd;
    logic          r_bank;
    logic [CW-1:0] r_d;
    logic [CW-1:0] r_g;
    logic [CW-1:0] r_np;
    logic [CW-1:0] r_k;
    logic          r_cp_valid;
    logic          cp_rd;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [IW-1:0] wr_data;

    function automatic logic [AW-1:0] loc(input logic bank, input logic [CW-1:0] idx);
        return bank ? AW'(AW'(idx) + AW'(MAX_REQUESTERS)) : AW'(idx);
    endfunction

    // Denied ids fill the new bank from the front and outsiders sit behind the
    // participants. Granted ids are parked in already-read slots of the old
    // bank and copied behind the denied ones once the walk is over.
    always_comb begin
        cp_rd   = i_ctl.copy && (r_k < r_g);
        rd_en   = i_ctl.rd || cp_rd;
        rd_addr = cp_rd ? loc(r_bank, r_k) : loc(r_bank, CW'(i_rd_pos));
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = loc(1'b0, CW'(i_clr_addr));
        wr_data = i_clr_addr;
        if (i_ctl.clr) begin
            wr_addr = loc(1'b0, CW'(i_clr_addr));
            wr_data = i_clr_addr;
        end else if (i_ctl.put_denied) begin
            wr_addr = loc(!r_bank, r_d);
            wr_data = i_put_id;
        end else if (i_ctl.put_granted) begin
            wr_addr = loc(r_bank, r_g);
            wr_data = i_put_id;
        end else if (i_ctl.put_np) begin
            wr_addr = loc(!r_bank, CW'(i_nproc + r_np));
            wr_data = i_put_id;
        end else if (r_cp_valid) begin
            wr_addr = loc(!r_bank, r_d);
            wr_data = r_rd;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank     <= 1'b0;
            r_d        <= '0;
            r_g        <= '0;
            r_np       <= '0;
            r_k        <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            r_cp_valid <= cp_rd;
            if (i_ctl.start) begin
                r_d  <= '0;
                r_g  <= '0;
                r_np <= '0;
                r_k  <= '0;
            end else begin
                if (i_ctl.put_denied || r_cp_valid) begin
                    r_d <= CW'(r_d + 1'b1);
                end
                if (i_ctl.put_granted) begin
                    r_g <= CW'(r_g + 1'b1);
                end
                if (i_ctl.put_np) begin
                    r_np <= CW'(r_np + 1'b1);
                end
                if (cp_rd) begin
                    r_k <= CW'(r_k + 1'b1);
                end
            end
            if (i_ctl.flip) begin
                r_bank <= !r_bank;
            end
        end
    end

    assign o_id        = r_rd;
    assign o_copy_done = (r_k == r_g) && !r_cp_valid;

    // Denied plus granted ids must fill exactly the participant slots.
    a_partition_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.flip |-> (r_d == i_nproc))
        else $error("order partition did not fill the participant slots");

endmodule

[hdl/memory_bank_arbiter_loser_priority.sv]
// Top level: configuration, sequencer, result staging and stream ports.
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser operation, tdata request fields
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata grant fields, tlast, tuser error
//  cfg       in         i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
// A load reads and then writes the requester entry; a load with a bank out of range
// waits for the result register to report an error. A cycle item walks the order and
// requester memories in a three-stage pipeline, then copies the granted ids behind the
// denied ones. After reset a clearing pass fills both memories; no item is taken.
// A stalled result output holds the walk only when a second grant result is ready.
`timescale 1ns / 1ps

module memory_bank_arbiter_loser_priority #(
    parameter int MAX_REQUESTERS = mbalp_pkg::DEF_MAX_REQUESTERS,
    parameter int MAX_BANKS      = mbalp_pkg::DEF_MAX_BANKS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mbalp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mbalp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // requester [3:0], module_index [9:4], zero fill [15:10]
    input  logic [mbalp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // operation
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // granted_requester [3:0], granted_module [9:4], wait_total [25:10],
    // grant_total [41:26], zero fill [47:42]
    output logic [mbalp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast,
    // error
    output logic                                m_axis_tuser
);

    localparam int IW       = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
    localparam int CW       = $clog2(MAX_REQUESTERS + 1);
    localparam int BANK_CAP = (MAX_BANKS < mbalp_pkg::MOD_CODES) ? MAX_BANKS
                                                                 : mbalp_pkg::MOD_CODES;
    localparam int GD_W     = 2 * mbalp_pkg::CNT_W + mbalp_pkg::MOD_W + mbalp_pkg::REQ_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LD_RD = 3'd2;
    localparam logic [2:0] S_LD_WR = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;
    localparam logic [2:0] S_COPY  = 3'd6;
    localparam logic [2:0] S_FLUSH = 3'd7;

    typedef struct packed {
        logic [mbalp_pkg::CNT_W-1:0] grant_total;
        logic [mbalp_pkg::CNT_W-1:0] wait_total;
        logic [mbalp_pkg::MOD_W-1:0] granted_module;
        logic [mbalp_pkg::REQ_W-1:0] granted_requester;
    } t_grant_data;

    logic [2:0]                       r_state;
    logic [2:0]                       n_state;
    logic [mbalp_pkg::AP_W-1:0]       r_ap;
    logic [mbalp_pkg::AM_W-1:0]       r_am;
    logic [IW-1:0]                    r_clr;
    logic [CW-1:0]                    r_pos;
    logic                             r_b_valid;
    logic                             r_c_valid;
    logic [IW-1:0]                    r_c_id;
    logic [IW-1:0]                    r_ld_addr;
    logic [mbalp_pkg::MOD_W-1:0]      r_ld_mod;
    logic [mbalp_pkg::RCNT_W-1:0]     r_cnt;
    t_grant_data                      r_pend;
    logic                             r_pend_valid;
    t_grant_data                      r_out;
    logic                             r_out_last;
    logic                             r_out_err;
    logic                             r_out_valid;

    logic                             in_fire;
    logic                             in_op;
    logic [mbalp_pkg::REQ_W-1:0]      in_req;
    logic [mbalp_pkg::MOD_W-1:0]      in_mod;
    logic [CW-1:0]                    nproc;
    logic [mbalp_pkg::AM_W-1:0]       nmod;
    logic                             out_free;
    logic                             in_walk;
    logic                             a_valid;
    logic                             participant;
    logic                             c_grant;
    logic                             c_report;
    logic                             adv;
    logic                             c_commit;
    logic                             start;
    logic                             out_load_err;
    logic                             out_load_walk;
    logic                             out_load_flush;
    t_grant_data                      new_grant;

    mbalp_pkg::t_ord_ctl              ord_ctl;
    mbalp_pkg::t_req_ctl              req_ctl;
    logic [IW-1:0]                    ord_id;
    logic                             ord_copy_done;
    logic [IW-1:0]                    req_rd_addr;
    logic [IW-1:0]                    req_wr_addr;
    mbalp_pkg::t_req_info             req_info;

    // ---------------------------------------------------------------- input side
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_req        = s_axis_tdata[mbalp_pkg::REQ_W-1:0];
    assign in_mod        = s_axis_tdata[mbalp_pkg::REQ_W +: mbalp_pkg::MOD_W];
    assign start         = in_fire && (in_op == mbalp_pkg::OP_CYCLE);

    always_comb begin
        nproc = (int'(r_ap) < MAX_REQUESTERS) ? CW'(r_ap) : CW'(MAX_REQUESTERS);
        nmod  = (int'(r_am) < BANK_CAP) ? r_am : mbalp_pkg::AM_W'(BANK_CAP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ap <= mbalp_pkg::AP_RESET;
            r_am <= mbalp_pkg::AM_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mbalp_pkg::CFG_ACTIVE_PROC: r_ap <= i_cfg_data[mbalp_pkg::AP_W-1:0];
                mbalp_pkg::CFG_ACTIVE_MOD:  r_am <= i_cfg_data[mbalp_pkg::AM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ld_addr <= IW'(in_req);
            r_ld_mod  <= in_mod;
        end
    end

    // ---------------------------------------------------------------- walk pipeline
    // Stage A reads the order slot, stage B reads that requester's entry,
    // stage C decides and writes back both memories.
    assign out_free    = !r_out_valid || m_axis_tready;
    assign in_walk     = (r_state == S_WALK);
    assign a_valid     = r_pos < CW'(MAX_REQUESTERS);
    assign participant = CW'(r_c_id) < nproc;
    assign c_grant     = participant && req_info.grant;
    assign c_report    = c_grant && (r_cnt < mbalp_pkg::RCNT_W'(mbalp_pkg::RESULT_LIMIT));
    assign adv         = !(r_c_valid && c_report && r_pend_valid && !out_free);
    assign c_commit    = in_walk && adv && r_c_valid;

    always_comb begin
        new_grant = '{
            grant_total:       req_info.grant_total,
            wait_total:        req_info.wait_total,
            granted_module:    req_info.module_idx,
            granted_requester: mbalp_pkg::REQ_W'(r_c_id)
        };
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (start) begin
            r_pos     <= '0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (in_walk && adv) begin
            if (a_valid) begin
                r_pos <= CW'(r_pos + 1'b1);
            end
            r_b_valid <= a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_walk && adv && r_b_valid) begin
            r_c_id <= ord_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr <= IW'(r_clr + 1'b1);
        end
    end

    // ---------------------------------------------------------------- memory controls
    always_comb begin
        ord_ctl.clr         = (r_state == S_CLEAR);
        ord_ctl.start       = start;
        ord_ctl.rd          = in_walk && adv && a_valid;
        ord_ctl.put_denied  = c_commit && participant && !req_info.grant;
        ord_ctl.put_granted = c_commit && c_grant;
        ord_ctl.put_np      = c_commit && !participant;
        ord_ctl.copy        = (r_state == S_COPY);
        ord_ctl.flip        = (r_state == S_COPY) && ord_copy_done;

        req_ctl.clr         = (r_state == S_CLEAR);
        req_ctl.rd          = (in_walk && adv && r_b_valid) || (r_state == S_LD_RD);
        req_ctl.upd         = c_commit && participant;
        req_ctl.ld_wr       = (r_state == S_LD_WR);
        req_ctl.busy_clr    = start;

        req_rd_addr = (r_state == S_LD_RD) ? r_ld_addr : ord_id;
        if (r_state == S_CLEAR) begin
            req_wr_addr = r_clr;
        end else if (r_state == S_LD_WR) begin
            req_wr_addr = r_ld_addr;
        end else begin
            req_wr_addr = r_c_id;
        end
    end

    mbalp_order_unit #(
        .MAX_REQUESTERS (MAX_REQUESTERS)
    ) u_order (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ord_ctl),
        .i_clr_addr  (r_clr),
        .i_rd_pos    (r_pos[IW-1:0]),
        .i_put_id    (r_c_id),
        .i_nproc     (nproc),
        .o_id        (ord_id),
        .o_copy_done (ord_copy_done)
    );

    mbalp_req_unit #(
        .MAX_REQUESTERS (MAX_REQUESTERS)
    ) u_req (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (req_ctl),
        .i_rd_addr (req_rd_addr),
        .i_wr_addr (req_wr_addr),
        .i_ld_mod  (r_ld_mod),
        .i_nmod    (nmod),
        .o_info    (req_info)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == IW'(MAX_REQUESTERS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    if (in_op == mbalp_pkg::OP_CYCLE) begin
                        n_state = S_WALK;
                    end else if (int'(in_req) < MAX_REQUESTERS) begin
                        if (mbalp_pkg::AM_W'(in_mod) >= nmod) begin
                            n_state = S_ERR;
                        end else begin
                            n_state = S_LD_RD;
                        end
                    end
                end
            end
            S_LD_RD: n_state = S_LD_WR;
            S_LD_WR: n_state = S_IDLE;
            S_ERR: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (!a_valid && !r_b_valid && !r_c_valid) begin
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                if (ord_copy_done) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------- results
    // The newest grant is held back one step so the final one can carry tlast.
    assign out_load_err   = (r_state == S_ERR) && out_free;
    assign out_load_walk  = c_commit && c_report && r_pend_valid;
    assign out_load_flush = (r_state == S_FLUSH) && r_pend_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_cnt        <= '0;
        end else if (start) begin
            r_pend_valid <= 1'b0;
            r_cnt        <= '0;
        end else if (c_commit && c_report) begin
            r_pend_valid <= 1'b1;
            r_cnt        <= mbalp_pkg::RCNT_W'(r_cnt + 1'b1);
        end else if (out_load_flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_commit && c_report) begin
            r_pend <= new_grant;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load_err || out_load_walk || out_load_flush) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load_err) begin
            r_out      <= '0;
            r_out_last <= 1'b0;
            r_out_err  <= 1'b1;
        end else if (out_load_walk || out_load_flush) begin
            r_out      <= r_pend;
            r_out_last <= out_load_flush;
            r_out_err  <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(mbalp_pkg::OUT_TDATA_W - GD_W)'(0), r_out};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_err;

    // ---------------------------------------------------------------- checks
    a_result_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mbalp_pkg::RCNT_W'(mbalp_pkg::RESULT_LIMIT))
        else $error("more grant results than the per-cycle limit");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_pend_valid && !r_b_valid && !r_c_valid))
        else $error("walk pipeline or held grant left over in idle");

    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> ((r_cnt != '0) == r_pend_valid))
        else $error("held grant does not match the grant count at flush");

endmodule

[bench/memory_bank_arbiter_loser_priority_tb.sv]
// Self-checking bench for the loser-priority memory bank arbiter, with an item-level predictor.
`timescale 1ns / 1ps

module memory_bank_arbiter_loser_priority_tb;
    import mbalp_pkg::*;

    localparam int NUM_PHASES  = 13;
    localparam int RAND_PER_PH = 47;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic             op;
        logic [REQ_W-1:0] requester;
        logic [MOD_W-1:0] module_idx;
    } t_arb_item;

    typedef struct packed {
        logic [REQ_W-1:0] requester;
        logic [MOD_W-1:0] module_idx;
        logic [CNT_W-1:0] waits;
        logic [CNT_W-1:0] grants;
        logic             last;
        logic             err;
    } t_grant_rec;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    memory_bank_arbiter_loser_priority dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predictor state.
    logic [AP_W-1:0]  procs_on;
    logic [AM_W-1:0]  banks_on;
    logic [REQ_W-1:0] prio_order [DEF_MAX_REQUESTERS];
    logic [MOD_W-1:0] want_bank  [DEF_MAX_REQUESTERS];
    logic [CNT_W-1:0] wait_cnt   [DEF_MAX_REQUESTERS];
    logic [CNT_W-1:0] grant_cnt  [DEF_MAX_REQUESTERS];

    t_arb_item  item_q [$];
    t_grant_rec grant_q [$];
    t_arb_item  cur_item;
    t_grant_rec want_rec;

    int items_queued  = 0;
    int items_taken   = 0;
    int mismatches    = 0;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one accepted item to the predictor and queues the grants it yields.
    function automatic void arbitrate_item(input t_arb_item it);
        int         nbanks;
        int         nprocs;
        int         cnt;
        int         k;
        int         id;
        int         m;
        bit         busy [DEF_MAX_BANKS];
        bit         won  [DEF_MAX_REQUESTERS];
        logic [REQ_W-1:0] nxt [DEF_MAX_REQUESTERS];
        t_grant_rec outs [RESULT_LIMIT];
        t_grant_rec rec;

        nbanks = (int'(banks_on) < DEF_MAX_BANKS) ? int'(banks_on) : DEF_MAX_BANKS;
        nprocs = (int'(procs_on) < DEF_MAX_REQUESTERS) ? int'(procs_on) : DEF_MAX_REQUESTERS;
        cnt = 0;
        if (it.op == OP_LOAD) begin
            if (int'(it.module_idx) >= nbanks) begin
                rec = '0;
                rec.err = 1'b1;
                grant_q.push_back(rec);
            end else begin
                want_bank[it.requester] = it.module_idx;
            end
            return;
        end
        foreach (busy[i]) busy[i] = 1'b0;
        foreach (won[i]) won[i] = 1'b0;
        for (int p = 0; p < DEF_MAX_REQUESTERS; p++) begin
            id = int'(prio_order[p]);
            if (id < nprocs) begin
                m = int'(want_bank[id]);
                if (m < nbanks && !busy[m]) begin
                    busy[m] = 1'b1;
                    won[id] = 1'b1;
                    if (grant_cnt[id] != '1) grant_cnt[id] = grant_cnt[id] + 1'b1;
                    if (cnt < RESULT_LIMIT) begin
                        rec = '0;
                        rec.requester  = REQ_W'(id);
                        rec.module_idx = MOD_W'(m);
                        rec.waits      = wait_cnt[id];
                        rec.grants     = grant_cnt[id];
                        outs[cnt] = rec;
                        cnt++;
                    end
                end else if (wait_cnt[id] != '1) begin
                    wait_cnt[id] = wait_cnt[id] + 1'b1;
                end
            end
        end
        if (cnt > 0) outs[cnt-1].last = 1'b1;
        for (int j = 0; j < cnt; j++) grant_q.push_back(outs[j]);
        // Stable partition: denied participants, granted participants, then the rest.
        k = 0;
        for (int p = 0; p < DEF_MAX_REQUESTERS; p++) begin
            id = int'(prio_order[p]);
            if (id < nprocs && !won[id]) begin nxt[k] = REQ_W'(id); k++; end
        end
        for (int p = 0; p < DEF_MAX_REQUESTERS; p++) begin
            id = int'(prio_order[p]);
            if (id < nprocs && won[id]) begin nxt[k] = REQ_W'(id); k++; end
        end
        for (int p = 0; p < DEF_MAX_REQUESTERS; p++) begin
            id = int'(prio_order[p]);
            if (id >= nprocs) begin nxt[k] = REQ_W'(id); k++; end
        end
        foreach (prio_order[i]) prio_order[i] = nxt[i];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task automatic queue_item(input logic op, input int req, input int bank);
        t_arb_item it;
        it.op         = op;
        it.requester  = REQ_W'(req);
        it.module_idx = MOD_W'(bank);
        item_q.push_back(it);
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_ACTIVE_PROC) procs_on = AP_W'(value);
        else banks_on = AM_W'(value);
    endtask

    // Waits until every item is taken and every grant is seen, then lets the block settle.
    task automatic wait_idle();
        while (items_taken != items_queued || grant_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly loads that contend for a few banks, with cycles mixed in and some bad banks.
    task automatic queue_random_items(input int n);
        int nbanks;
        int nprocs;
        int req;
        int bank;
        int pick;
        nbanks = (int'(banks_on) < DEF_MAX_BANKS) ? int'(banks_on) : DEF_MAX_BANKS;
        nprocs = (int'(procs_on) < DEF_MAX_REQUESTERS) ? int'(procs_on) : DEF_MAX_REQUESTERS;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 35) begin
                queue_item(OP_CYCLE, $urandom_range(0, 15), $urandom_range(0, 63));
            end else begin
                if (nprocs > 0 && $urandom_range(0, 99) < 80) req = $urandom_range(0, nprocs - 1);
                else req = $urandom_range(0, 15);
                pick = $urandom_range(0, 99);
                if (nbanks == 0 || pick >= 85) bank = $urandom_range(0, 63);
                else if (pick < 40) bank = $urandom_range(0, (nbanks < 4 ? nbanks : 4) - 1);
                else bank = $urandom_range(0, nbanks - 1);
                queue_item(OP_LOAD, req, bank);
            end
        end
    endtask

    task automatic set_idling(input int phase);
        case (phase * 3 / NUM_PHASES)
            0: begin send_idle_pct = 11; recv_idle_pct = 55; end
            1: begin send_idle_pct = 55; recv_idle_pct = 11; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    // Driver: presents queued items and feeds each accepted one to the predictor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                arbitrate_item(cur_item);
                items_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item = item_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cur_item.op;
                    s_axis_tdata  <= {{(IN_TDATA_W - REQ_W - MOD_W){1'b0}},
                                      cur_item.module_idx, cur_item.requester};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and field-by-field comparison of each result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (grant_q.size() == 0) begin
                    report_mismatch("result with nothing expected",
                                    int'(m_axis_tdata[REQ_W-1:0]), 0);
                end else begin
                    want_rec = grant_q.pop_front();
                    if (m_axis_tdata[REQ_W-1:0] != want_rec.requester)
                        report_mismatch("granted_requester", int'(m_axis_tdata[REQ_W-1:0]),
                                        int'(want_rec.requester));
                    if (m_axis_tdata[REQ_W +: MOD_W] != want_rec.module_idx)
                        report_mismatch("granted_module", int'(m_axis_tdata[REQ_W +: MOD_W]),
                                        int'(want_rec.module_idx));
                    if (m_axis_tdata[REQ_W+MOD_W +: CNT_W] != want_rec.waits)
                        report_mismatch("wait_total", int'(m_axis_tdata[REQ_W+MOD_W +: CNT_W]),
                                        int'(want_rec.waits));
                    if (m_axis_tdata[REQ_W+MOD_W+CNT_W +: CNT_W] != want_rec.grants)
                        report_mismatch("grant_total",
                                        int'(m_axis_tdata[REQ_W+MOD_W+CNT_W +: CNT_W]),
                                        int'(want_rec.grants));
                    if (m_axis_tlast != want_rec.last)
                        report_mismatch("last_grant", int'(m_axis_tlast), int'(want_rec.last));
                    if (m_axis_tuser != want_rec.err)
                        report_mismatch("error", int'(m_axis_tuser), int'(want_rec.err));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int procs_set [NUM_PHASES];
        int banks_set [NUM_PHASES];
        procs_set = '{16, 4, 0, 16, 1, 8, 3, 16, 31, 12, 5, 2, 6};
        banks_set = '{64, 10, 64, 64, 1, 32, 5, 17, 127, 40, 64, 2, 0};
        procs_on = AP_RESET;
        banks_on = AM_RESET;
        for (int i = 0; i < DEF_MAX_REQUESTERS; i++) begin
            prio_order[i] = REQ_W'(i);
            want_bank[i]  = '0;
            wait_cnt[i]   = '0;
            grant_cnt[i]  = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_idling(ph);
            write_reg(CFG_ACTIVE_PROC, procs_set[ph]);
            write_reg(CFG_ACTIVE_MOD, banks_set[ph]);
            case (ph)
                0: begin
                    // Sixteen distinct banks, so every requester wins, including the extremes.
                    for (int r = 0; r < DEF_MAX_REQUESTERS; r++)
                        queue_item(OP_LOAD, r, 63 - 4 * r);
                    queue_item(OP_LOAD, 0, 0);
                    queue_item(OP_CYCLE, 0, 0);
                    // A collision on bank zero, then the loser goes first next cycle.
                    queue_item(OP_LOAD, 1, 0);
                    queue_item(OP_CYCLE, 15, 63);
                    queue_item(OP_CYCLE, 0, 0);
                end
                1: begin
                    // Banks out of range are flagged; the older requests above ten go stale.
                    queue_item(OP_LOAD, 2, 12);
                    queue_item(OP_LOAD, 3, 63);
                    queue_item(OP_CYCLE, 0, 0);
                end
                2: begin
                    // No participants: the cycle yields no grant at all.
                    queue_item(OP_CYCLE, 0, 0);
                end
                default: queue_random_items(RAND_PER_PH);
            endcase
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
